[hdl/rgb_to_hsv_pixel_top_macros.svh]
// Assertion macros for the RGB to HSV pixel converter.
// The including module provides clk and rst.
`ifndef RGB_TO_HSV_PIXEL_TOP_MACROS_SVH
`define RGB_TO_HSV_PIXEL_TOP_MACROS_SVH

// Property checked outside reset
`define RHSV_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Property that must also hold across reset
`define RHSV_CHECK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

[hdl/rhsv_pkg.sv]
`default_nettype none

package rhsv_pkg;

  // Pixel and result formats
  localparam int PIX_W         = 8;
  localparam int HUE_FRAC_BITS = 6;
  localparam int SAT_FRAC_BITS = 12;
  localparam int HUE_W         = 9 + HUE_FRAC_BITS;
  localparam int SAT_W         = SAT_FRAC_BITS + 1;

  // Divider operand widths: hue numerator is at most 360 * 255 (degrees times d)
  localparam int NUM_W  = 17;
  localparam int DEN_W  = PIX_W + 1;
  localparam int HDVD_W = NUM_W + HUE_FRAC_BITS + 1;
  localparam int SDVD_W = PIX_W + SAT_FRAC_BITS + 1;

  // Divider pipeline: STEP_BITS quotient bits resolved per stage
  localparam int QW        = (HUE_W > SAT_W) ? HUE_W : SAT_W;
  localparam int STEP_BITS = 3;
  localparam int NDIV      = (QW + STEP_BITS - 1) / STEP_BITS;
  localparam int QPAD      = NDIV * STEP_BITS;
  localparam int DVD_W     = (HDVD_W > SDVD_W) ? HDVD_W : SDVD_W;
  localparam int SHD_W     = DEN_W + QPAD - 1;
  localparam int CW        = (DVD_W > SHD_W) ? DVD_W : SHD_W;

  // Front stage, operand stage, divider stages, output register
  localparam int NST = NDIV + 3;

  // Angle constants in degrees
  localparam logic [NUM_W-1:0] DEG_60  = NUM_W'(60);
  localparam logic [NUM_W-1:0] DEG_120 = NUM_W'(120);
  localparam logic [NUM_W-1:0] DEG_240 = NUM_W'(240);
  localparam logic [NUM_W-1:0] DEG_360 = NUM_W'(360);

  localparam logic [HUE_W-1:0] HUE_FULL = HUE_W'(360 << HUE_FRAC_BITS);
  localparam logic [SAT_W-1:0] SAT_ONE  = SAT_W'(1 << SAT_FRAC_BITS);

  // Hue sector, picked in order red, green, blue
  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  // After the max/min stage
  typedef struct packed {
    logic [PIX_W-1:0] mx;
    logic [PIX_W-1:0] d;
    sector_t          sector;
    logic             pos;
    logic [PIX_W-1:0] mag;
  } front_t;

  // One division in flight: partial remainder, quotient so far, divisor
  typedef struct packed {
    logic [CW-1:0]    rem;
    logic [QPAD-1:0]  quo;
    logic [DEN_W-1:0] den;
  } div_lane_t;

  // Stage word through the divider pipeline
  typedef struct packed {
    div_lane_t        hue;
    div_lane_t        sat;
    logic             gray;
    logic             black;
    logic [PIX_W-1:0] mx;
  } pipe_t;

  // Restoring division, STEP_BITS quotient bits starting at bit top
  function automatic div_lane_t div_lane_step(div_lane_t a, int unsigned top);
    div_lane_t     r;
    logic [CW-1:0] sh;
    r = a;
    for (int unsigned k = 0; k < STEP_BITS; k++) begin
      sh = CW'(r.den) << (top - k);
      if (r.rem >= sh) begin
        r.rem = r.rem - sh;
        r.quo = {r.quo[QPAD-2:0], 1'b1};
      end else begin
        r.quo = {r.quo[QPAD-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/rgb_to_hsv_pixel_top.sv]
`default_nettype none
// RGB to HSV pixel converter.
// Input channel pix_*: one 8-bit red, green, blue pixel per transfer.
// Output channel hsv_*: hue in 1/64 degree (0..23039), saturation in Q1.12
// (4096 is 1.0) and brightness as the largest component byte.
// Gray pixels give hue 0; black pixels give hue 0 and saturation 0.
// Throughput: one pixel per clock while hsv_stall is low.
// Path from input transfer to hsv_valid: the transfer edge loads the
// max/min stage; then come one operand stage, five divider stages
// (three quotient bits each for both the hue and the saturation division)
// and the output register.
// Every stage carries its own valid bit and loads whenever it is empty or
// its successor is loading, so bubbles close up under a stall.
// pix_stall rises only when all eight stages hold a pixel and hsv_stall is
// high; a stalled result holds on the output ports.
// Synchronous reset clears the valid bits; no pixel is in flight after it.
module rgb_to_hsv_pixel_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       pix_valid,
  output logic                            pix_stall,
  input  wire logic [rhsv_pkg::PIX_W-1:0] red,
  input  wire logic [rhsv_pkg::PIX_W-1:0] green,
  input  wire logic [rhsv_pkg::PIX_W-1:0] blue,
  output logic                            hsv_valid,
  input  wire logic                       hsv_stall,
  output logic [rhsv_pkg::HUE_W-1:0]      hue,
  output logic [rhsv_pkg::SAT_W-1:0]      saturation,
  output logic [rhsv_pkg::PIX_W-1:0]      brightness
);
  import rhsv_pkg::*;

  logic [NST-1:0] vld;
  logic [NST-1:0] rdy;

  front_t front_next;
  front_t p1;
  pipe_t  p2_next;
  pipe_t  p2;
  pipe_t  dv [NDIV];
  pipe_t  dv_next [NDIV];

  logic [HUE_W-1:0] hue_next;
  logic [SAT_W-1:0] saturation_next;

  // Ready chain: a stage loads when empty or when its successor loads
  always_comb begin
    rdy[NST-1] = !vld[NST-1] || !hsv_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign pix_stall = !rdy[0];
  assign hsv_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= pix_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 1: max, min, sector and the signed difference for the sector
  always_comb begin
    logic [PIX_W-1:0] mn;
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] b;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    if (red >= green && red >= blue) begin
      front_next.sector = SEC_RED;
      front_next.mx     = red;
      a = green;
      b = blue;
    end else if (green >= blue) begin
      front_next.sector = SEC_GREEN;
      front_next.mx     = green;
      a = blue;
      b = red;
    end else begin
      front_next.sector = SEC_BLUE;
      front_next.mx     = blue;
      a = red;
      b = green;
    end
    front_next.d   = front_next.mx - mn;
    front_next.pos = (a >= b);
    front_next.mag = (a >= b) ? (a - b) : (b - a);
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      p1 <= front_next;
    end
  end

  // Stage 2: hue numerator and both division operands, rounding folded in
  always_comb begin
    logic [NUM_W-1:0] base_deg;
    logic [NUM_W-1:0] base_term;
    logic [NUM_W-1:0] step_term;
    logic [NUM_W-1:0] num;
    case (p1.sector)
      SEC_RED:   base_deg = p1.pos ? '0 : DEG_360;
      SEC_GREEN: base_deg = DEG_120;
      SEC_BLUE:  base_deg = DEG_240;
      default:   base_deg = '0;
    endcase
    base_term = NUM_W'(base_deg * NUM_W'(p1.d));
    step_term = NUM_W'(DEG_60 * NUM_W'(p1.mag));
    num = p1.pos ? (base_term + step_term) : (base_term - step_term);

    p2_next.hue.rem = CW'((HDVD_W'(num) << (HUE_FRAC_BITS + 1)) + HDVD_W'(p1.d));
    p2_next.hue.quo = '0;
    p2_next.hue.den = DEN_W'(p1.d) << 1;
    p2_next.sat.rem = CW'((SDVD_W'(p1.d) << (SAT_FRAC_BITS + 1)) + SDVD_W'(p1.mx));
    p2_next.sat.quo = '0;
    p2_next.sat.den = DEN_W'(p1.mx) << 1;
    p2_next.gray    = (p1.d == '0);
    p2_next.black   = (p1.mx == '0);
    p2_next.mx      = p1.mx;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      p2 <= p2_next;
    end
  end

  // Divider stages: each resolves STEP_BITS quotient bits of both divisions
  for (genvar s = 0; s < NDIV; s++) begin : g_div
    always_comb begin
      pipe_t src;
      src = (s == 0) ? p2 : dv[(s == 0) ? 0 : s - 1];
      dv_next[s]     = src;
      dv_next[s].hue = div_lane_step(src.hue, QPAD - 1 - s * STEP_BITS);
      dv_next[s].sat = div_lane_step(src.sat, QPAD - 1 - s * STEP_BITS);
    end

    always_ff @(posedge clk) begin
      if (rdy[s + 2]) begin
        dv[s] <= dv_next[s];
      end
    end
  end

  // Output stage: wrap a full circle, zero hue for gray, zero sat for black
  always_comb begin
    if (dv[NDIV-1].gray || dv[NDIV-1].hue.quo >= QPAD'(HUE_FULL)) begin
      hue_next = '0;
    end else begin
      hue_next = dv[NDIV-1].hue.quo[HUE_W-1:0];
    end
    saturation_next = dv[NDIV-1].black ? '0 : dv[NDIV-1].sat.quo[SAT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[NST-1]) begin
      hue        <= hue_next;
      saturation <= saturation_next;
      brightness <= dv[NDIV-1].mx;
    end
  end

endmodule

`default_nettype wire

[hdl/rhsv_checker.sv]
`default_nettype none
`include "rgb_to_hsv_pixel_top_macros.svh"

// Port-level checks on the converter
module rhsv_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       pix_stall,
  input wire logic                       hsv_valid,
  input wire logic                       hsv_stall,
  input wire logic [rhsv_pkg::HUE_W-1:0] hue,
  input wire logic [rhsv_pkg::SAT_W-1:0] saturation,
  input wire logic [rhsv_pkg::PIX_W-1:0] brightness
);
  import rhsv_pkg::*;

  // Reset leaves nothing in flight
  `RHSV_CHECK_RST(a_rst_empty, rst |=> !hsv_valid, "result valid straight after reset")

  // Input only backs up when the output is blocked
  `RHSV_CHECK(a_stall_cause, pix_stall |-> (hsv_valid && hsv_stall), "input stalled while output free")

  // Hue stays below a full circle, saturation at or below one
  `RHSV_CHECK(a_range, hsv_valid |-> (hue < HUE_FULL && saturation <= SAT_ONE), "hue or saturation out of range")

  // Black pixel gives zero hue and zero saturation
  `RHSV_CHECK(a_black, (hsv_valid && brightness == '0) |-> (hue == '0 && saturation == '0), "black pixel with colour")

  // Stalled result holds until its transfer
  `RHSV_CHECK(a_hold, (hsv_valid && hsv_stall) |=> (hsv_valid && $stable(hue) && $stable(saturation) && $stable(brightness)), "stalled result changed")

endmodule

bind rgb_to_hsv_pixel_top rhsv_checker u_rhsv_checker (.*);

`default_nettype wire
